// File: src/lmsa_pkg.sv
// ----------------------------------------------------------------------------
// lmsa_pkg
// Shared types and constants of the LED matrix status animator.
// ----------------------------------------------------------------------------
package lmsa_pkg;

   // matrix geometry
   localparam int unsigned MATRIX_SIZE = 5;
   localparam int unsigned PIXEL_COUNT = MATRIX_SIZE * MATRIX_SIZE;
   localparam int unsigned PIX_W       = $clog2(PIXEL_COUNT);
   localparam int unsigned COL_W       = $clog2(MATRIX_SIZE);

   // stop sign covers rows 0..2 and columns 1..3
   localparam logic [PIX_W-1:0] SIGN_END_INDEX = PIX_W'(3 * MATRIX_SIZE);
   localparam logic [COL_W-1:0] SIGN_COL_LO    = COL_W'(1);
   localparam logic [COL_W-1:0] SIGN_COL_HI    = COL_W'(3);
   localparam logic [COL_W-1:0] COL_LAST       = COL_W'(MATRIX_SIZE - 1);
   localparam logic [PIX_W-1:0] PIX_LAST       = PIX_W'(PIXEL_COUNT - 1);

   // ring animation
   localparam int unsigned RING_COUNT = 8;
   localparam logic [PIX_W-1:0] RING_LAST = PIX_W'(RING_COUNT - 1);
   localparam logic [PIX_W-1:0] RING_PIXELS [RING_COUNT] = '{
      5'd1, 5'd2, 5'd3, 5'd8, 5'd13, 5'd12, 5'd11, 5'd6
   };
   localparam logic [7:0] RING_PHASE_STEP = 8'd31;
   localparam logic [7:0] RING_RISE_END   = 8'd100;
   localparam logic [7:0] RING_FALL_END   = 8'd200;

   // power fade
   localparam logic [6:0] FADE_RESET_LEVEL = 7'd2;
   localparam logic [6:0] FADE_RISE_STEP   = 7'd14;
   localparam logic [6:0] FADE_FALL_STEP   = 7'd8;
   localparam logic [6:0] FADE_RELOAD      = 7'd96;
   localparam logic [6:0] LEVEL_FULL       = 7'd100;
   localparam logic [6:0] LEVEL_OFF        = 7'd0;

   localparam logic [7:0] PATTERN_STEP_RESET = 8'd9;

   // request modes
   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_SET    = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_PROGRAM  = 2'd0;
   localparam logic [1:0] STATUS_SHUTDOWN = 2'd1;

   typedef enum logic [1:0] {
      ANIM_NONE = 2'd0,
      ANIM_FADE = 2'd1,
      ANIM_RING = 2'd2
   } anim_kind_type;

   // draw command from front to back end
   typedef struct packed {
      logic       is_ring;
      logic [7:0] value;   // sign level or ring start phase
   } cmd_type;

endpackage

// File: src/lmsa_front.sv
// ----------------------------------------------------------------------------
// lmsa_front
// Accepts status events and ticks, keeps the animation state and issues
// draw commands into the command queue.
// ----------------------------------------------------------------------------
module lmsa_front import lmsa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [1:0] mode,
   input  logic [1:0] status_code,
   input  logic       program_running_now,
   input  logic       shutdown_requested_now,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   output logic       cmd_push,
   output cmd_type    cmd
);

   anim_kind_type anim_kind_ff, anim_kind_in;
   logic [6:0]    fade_level_ff, fade_level_in;
   logic          fade_falling_ff, fade_falling_in;
   logic [7:0]    ring_phase_ff, ring_phase_in;
   logic [7:0]    pattern_step_ff;
   logic [6:0]    fade_next;

   // next fade level, 7-bit wrap
   assign fade_next = fade_falling_ff ? (fade_level_ff - FADE_FALL_STEP)
                                      : (fade_level_ff + FADE_RISE_STEP);

   // classify the request and update the animation state
   always_comb begin
      anim_kind_in    = anim_kind_ff;
      fade_level_in   = fade_level_ff;
      fade_falling_in = fade_falling_ff;
      ring_phase_in   = ring_phase_ff;
      cmd_push        = 1'b0;
      cmd.is_ring     = 1'b0;
      cmd.value       = 8'd0;
      if (accept) begin
         case (mode)
            MODE_TICK: begin
               case (anim_kind_ff)
                  ANIM_FADE: begin
                     cmd_push      = 1'b1;
                     cmd.value     = {1'b0, fade_next};
                     fade_level_in = fade_next;
                     if (fade_next == LEVEL_FULL || fade_next == LEVEL_OFF) begin
                        anim_kind_in    = ANIM_NONE;
                        fade_level_in   = FADE_RELOAD;
                        fade_falling_in = 1'b1;
                     end
                  end
                  ANIM_RING: begin
                     cmd_push      = 1'b1;
                     cmd.is_ring   = 1'b1;
                     cmd.value     = ring_phase_ff;
                     ring_phase_in = ring_phase_ff + pattern_step_ff;
                  end
                  default: ;
               endcase
            end
            MODE_SET: begin
               if (status_code == STATUS_PROGRAM) begin
                  cmd_push     = 1'b1;
                  cmd.value    = {1'b0, LEVEL_OFF};
                  anim_kind_in = ANIM_RING;
               end else if (status_code == STATUS_SHUTDOWN && !program_running_now) begin
                  anim_kind_in = ANIM_FADE;
               end
            end
            MODE_CLEAR: begin
               if (status_code == STATUS_PROGRAM) begin
                  if (shutdown_requested_now) begin
                     anim_kind_in = ANIM_FADE;
                  end else begin
                     cmd_push     = 1'b1;
                     cmd.value    = {1'b0, LEVEL_FULL};
                     anim_kind_in = ANIM_NONE;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         anim_kind_ff    <= ANIM_FADE;
         fade_level_ff   <= FADE_RESET_LEVEL;
         fade_falling_ff <= 1'b0;
         ring_phase_ff   <= 8'd0;
         pattern_step_ff <= PATTERN_STEP_RESET;
      end else begin
         anim_kind_ff    <= anim_kind_in;
         fade_level_ff   <= fade_level_in;
         fade_falling_ff <= fade_falling_in;
         ring_phase_ff   <= ring_phase_in;
         if (csr_we) begin
            pattern_step_ff <= csr_wdata;
         end
      end
   end

endmodule

// File: src/lmsa_cmdq.sv
// ----------------------------------------------------------------------------
// lmsa_cmdq
// Small register queue of draw commands between front and back end.
// ----------------------------------------------------------------------------
module lmsa_cmdq import lmsa_pkg::*; #(
   parameter int unsigned DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output logic    full,
   output logic    valid,
   output cmd_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign valid   = (count_ff != '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/lmsa_back.sv
// ----------------------------------------------------------------------------
// lmsa_back
// Expands draw commands into pixel writes, one per cycle, into an output
// register that holds while the consumer stalls.
// ----------------------------------------------------------------------------
module lmsa_back import lmsa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  cmd_type          cmd,
   output logic             cmd_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic [PIX_W-1:0] rsp_pixel_index,
   output logic [6:0]       rsp_pixel_level,
   output logic             rsp_last_write
);

   logic             busy_ff, busy_in;
   cmd_type          cur_ff, cur_in;
   logic [PIX_W-1:0] cnt_ff, cnt_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [7:0]       off_ff, off_in;
   logic             out_valid_ff, out_valid_in;
   logic [PIX_W-1:0] out_index_ff;
   logic [6:0]       out_level_ff;
   logic             out_last_ff;

   logic             out_ready, emit, last, sign_on;
   logic [PIX_W-1:0] pix_index;
   logic [6:0]       pix_level, ring_level;

   assign out_ready = !out_valid_ff || rsp_pop;
   assign emit      = busy_ff && out_ready;
   assign last      = cur_ff.is_ring ? (cnt_ff == RING_LAST) : (cnt_ff == PIX_LAST);
   assign cmd_pop   = cmd_valid && (!busy_ff || (emit && last));

   // triangle wave for the ring pixels
   always_comb begin
      if (off_ff > RING_FALL_END) begin
         ring_level = LEVEL_OFF;
      end else if (off_ff < RING_RISE_END) begin
         ring_level = off_ff[6:0];
      end else begin
         ring_level = 7'(RING_FALL_END - off_ff);
      end
   end

   // pixel index and level of the current write
   always_comb begin
      sign_on = (cnt_ff < SIGN_END_INDEX) && (col_ff inside {[SIGN_COL_LO:SIGN_COL_HI]});
      if (cur_ff.is_ring) begin
         pix_index = RING_PIXELS[cnt_ff[2:0]];
         pix_level = ring_level;
      end else begin
         pix_index = cnt_ff;
         pix_level = sign_on ? cur_ff.value[6:0] : LEVEL_OFF;
      end
   end

   // sequencer over the pixels of one command
   always_comb begin
      busy_in = busy_ff;
      cur_in  = cur_ff;
      cnt_in  = cnt_ff;
      col_in  = col_ff;
      off_in  = off_ff;
      if (emit) begin
         cnt_in = cnt_ff + 1'b1;
         col_in = (col_ff == COL_LAST) ? '0 : col_ff + 1'b1;
         off_in = off_ff + RING_PHASE_STEP;
         if (last) begin
            busy_in = 1'b0;
         end
      end
      if (cmd_pop) begin
         busy_in = 1'b1;
         cur_in  = cmd;
         cnt_in  = '0;
         col_in  = '0;
         off_in  = cmd.value;
      end
   end

   // output register valid
   always_comb begin
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      cnt_ff <= cnt_in;
      col_ff <= col_in;
      off_ff <= off_in;
      if (emit) begin
         out_index_ff <= pix_index;
         out_level_ff <= pix_level;
         out_last_ff  <= last;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_pixel_index = out_index_ff;
   assign rsp_pixel_level = out_level_ff;
   assign rsp_last_write  = out_last_ff;

endmodule

// File: src/led_matrix_status_animator.sv
// ----------------------------------------------------------------------------
// led_matrix_status_animator
// Turns status events and animation ticks into pixel writes for a 5x5
// LED matrix.
// ----------------------------------------------------------------------------
// Request side is a queue input: a request is taken when req_push is high and
// req_full is low. Each request carries a mode (tick, status set, status
// cleared), a status code and two status flags. Response side is a queue
// output: while rsp_empty is low the oldest pixel write is on rsp_*, and it
// is taken when rsp_pop is high. rsp_last_write marks the final write of a
// request; requests that draw nothing produce no writes.
// csr_we/csr_wdata set the ring phase step; the user must write it only while
// idle, the block does not enforce this. The front end updates the animation
// state and queues at most one draw command per request in the same cycle.
// Unless stalled, the back end emits one pixel per cycle and runs commands
// back to back; a sign or clear writes 25 pixels, a ring tick 8. From idle,
// a first write passes the command queue, command and output registers.
// If the consumer stalls, the output register holds, the back end waits,
// and once the command queue fills req_full rises.
// Reset empties both queues, starts the power fade at level 2 and sets the
// ring step to 9.
// ----------------------------------------------------------------------------
module led_matrix_status_animator import lmsa_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [1:0]       req_mode,
   input  logic [1:0]       req_status_code,
   input  logic             req_program_running_now,
   input  logic             req_shutdown_requested_now,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [PIX_W-1:0] rsp_pixel_index,
   output logic [6:0]       rsp_pixel_level,
   output logic             rsp_last_write,
   input  logic             csr_we,
   input  logic [7:0]       csr_wdata
);

   logic    accept;
   logic    q_push, q_pop, q_valid;
   cmd_type q_in, q_head;

   assign accept = req_push && !req_full;

   // front end: classify requests and keep animation state
   lmsa_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .accept                 (accept),
      .mode                   (req_mode),
      .status_code            (req_status_code),
      .program_running_now    (req_program_running_now),
      .shutdown_requested_now (req_shutdown_requested_now),
      .csr_we                 (csr_we),
      .csr_wdata              (csr_wdata),
      .cmd_push               (q_push),
      .cmd                    (q_in)
   );

   // command queue between the two ends
   lmsa_cmdq #(
      .DEPTH (QUEUE_DEPTH)
   ) u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .full      (req_full),
      .valid     (q_valid),
      .head      (q_head)
   );

   // back end: pixel writer
   lmsa_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (q_valid),
      .cmd             (q_head),
      .cmd_pop         (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_pixel_level (rsp_pixel_level),
      .rsp_last_write  (rsp_last_write)
   );

   // no response right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("response present right after reset");

   // back end only takes commands that are there
   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("command taken from empty queue");

   // written pixels stay on the matrix and in range
   a_pixel_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_pixel_index <= PIX_LAST && rsp_pixel_level <= LEVEL_FULL))
      else $error("pixel write out of range");

   // a command is queued only for an accepted request
   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      q_push |-> accept)
      else $error("command queued without a request");

endmodule

// File: tb/tb_led_matrix_status_animator.sv
// ----------------------------------------------------------------------------
// tb_led_matrix_status_animator
// Self-checking bench for the LED matrix status animator. A scoreboard keeps
// its own copy of the fade, ring and step state and queues the pixel writes
// each accepted request should produce. Every popped write is compared
// against that queue. A directed pass walks the fade, the ring and every
// status case. Random requests follow under several ring step settings, with
// random gaps on both queue sides and one long consumer hold-off.
// ----------------------------------------------------------------------------
module tb_led_matrix_status_animator;
   timeunit 1ns;
   timeprecision 1ps;

   import lmsa_pkg::*;

   // request codes with no name in the package
   localparam logic [1:0] MODE_SPARE     = 2'd3;
   localparam logic [1:0] STATUS_OTHER   = 2'd2;
   localparam logic [1:0] STATUS_SPARE   = 2'd3;

   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 400;
   localparam int REPORT_CAP    = 30;

   typedef struct packed {
      logic [PIX_W-1:0] index;
      logic [6:0]       level;
      logic             last;
   } pixel_write_type;

   // scoreboard: animation state and the queue of pixel writes still due
   class pixel_scoreboard;
      anim_kind_type   anim;
      logic [6:0]      fade_level;
      logic            fade_falling;
      logic [7:0]      ring_phase;
      logic [7:0]      ring_step;
      int unsigned     ring_order [8] = '{1, 2, 3, 8, 13, 12, 11, 6};
      pixel_write_type pending [$];
      int              errors;

      function new();
         anim         = ANIM_FADE;
         fade_level   = 7'd2;
         fade_falling = 1'b0;
         ring_phase   = 8'd0;
         ring_step    = 8'd9;
         errors       = 0;
      endfunction

      // stop sign: rows 0..2, columns 1..3 lit, the rest dark
      function void draw_sign(logic [6:0] lvl);
         pixel_write_type w;
         for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < 5; c++) begin
               w.index = PIX_W'(r * 5 + c);
               w.level = (r < 3 && c > 0 && c < 4) ? lvl : 7'd0;
               w.last  = 1'b0;
               pending.push_back(w);
            end
         end
      endfunction

      // triangle wave over eight ring pixels, then advance the phase
      function void draw_ring();
         pixel_write_type w;
         int              off;
         for (int k = 0; k < 8; k++) begin
            off     = (int'(ring_phase) + 31 * k) % 256;
            w.index = PIX_W'(ring_order[k]);
            w.level = (off > 200) ? 7'd0 : (off < 100) ? 7'(off) : 7'(200 - off);
            w.last  = 1'b0;
            pending.push_back(w);
         end
         ring_phase = ring_phase + ring_step;
      endfunction

      function void note_request(logic [1:0] mode, logic [1:0] code,
                                 logic running, logic shutdown);
         int first;
         first = pending.size();
         case (mode)
            MODE_TICK: begin
               if (anim == ANIM_FADE) begin
                  fade_level = fade_falling ? fade_level - 7'd8 : fade_level + 7'd14;
                  draw_sign(fade_level);
                  if (fade_level == 7'd100 || fade_level == 7'd0) begin
                     anim         = ANIM_NONE;
                     fade_level   = 7'd96;
                     fade_falling = 1'b1;
                  end
               end else if (anim == ANIM_RING) begin
                  draw_ring();
               end
            end
            MODE_SET: begin
               if (code == STATUS_PROGRAM) begin
                  draw_sign(7'd0);
                  anim = ANIM_RING;
               end else if (code == STATUS_SHUTDOWN && !running) begin
                  anim = ANIM_FADE;
               end
            end
            MODE_CLEAR: begin
               if (code == STATUS_PROGRAM) begin
                  if (shutdown) begin
                     anim = ANIM_FADE;
                  end else begin
                     draw_sign(7'd100);
                     anim = ANIM_NONE;
                  end
               end
            end
            default: ;
         endcase
         if (pending.size() > first) pending[$].last = 1'b1;
      endfunction

      function void report(string field, int want, int got);
         errors++;
         if (errors <= REPORT_CAP)
            $error("%s: expected %0d, actual %0d", field, want, got);
      endfunction

      function void check_write(logic [PIX_W-1:0] index, logic [6:0] level, logic last);
         pixel_write_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP)
               $error("pixel write with none due: index %0d level %0d", index, level);
            return;
         end
         want = pending.pop_front();
         if (index !== want.index) report("pixel_index", want.index, index);
         if (level !== want.level) report("pixel_level", want.level, level);
         if (last !== want.last)   report("last_write", want.last, last);
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   logic [1:0]       req_mode = MODE_TICK;
   logic [1:0]       req_status_code = STATUS_PROGRAM;
   logic             req_program_running_now = 1'b0;
   logic             req_shutdown_requested_now = 1'b0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   logic [PIX_W-1:0] rsp_pixel_index;
   logic [6:0]       rsp_pixel_level;
   logic             rsp_last_write;
   logic             csr_we = 1'b0;
   logic [7:0]       csr_wdata = 8'd0;

   pixel_scoreboard sb = new();
   bit              steady = 1'b0;
   bit              stall_request = 1'b0;

   led_matrix_status_animator dut (
      .clock                      (clock),
      .reset                      (reset),
      .req_push                   (req_push),
      .req_full                   (req_full),
      .req_mode                   (req_mode),
      .req_status_code            (req_status_code),
      .req_program_running_now    (req_program_running_now),
      .req_shutdown_requested_now (req_shutdown_requested_now),
      .rsp_empty                  (rsp_empty),
      .rsp_pop                    (rsp_pop),
      .rsp_pixel_index            (rsp_pixel_index),
      .rsp_pixel_level            (rsp_pixel_level),
      .rsp_last_write             (rsp_last_write),
      .csr_we                     (csr_we),
      .csr_wdata                  (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // consumer side, with an optional long hold-off
   initial begin
      int hold_left;
      int pop_gap;
      hold_left = 0;
      pop_gap   = 0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            hold_left     = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (pop_gap > 0) begin
            pop_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            pop_gap = pick_gap();
         end
      end
   end

   // compare every popped pixel write
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_write(rsp_pixel_index, rsp_pixel_level, rsp_last_write);
   end

   // offer one request, leave push high after acceptance
   task automatic send_request(input logic [1:0] mode, input logic [1:0] code,
                               input logic running, input logic shutdown);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_push        <= 1'b0;
         req_mode        <= 2'($urandom);
         req_status_code <= 2'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_push                   <= 1'b1;
      req_mode                   <= mode;
      req_status_code            <= code;
      req_program_running_now    <= running;
      req_shutdown_requested_now <= shutdown;
      do @(posedge clock); while (req_full);
      sb.note_request(mode, code, running, shutdown);
   endtask

   // mixed traffic: mostly ticks, program and shutdown events, some unused codes
   task automatic send_random(input int count);
      logic [1:0] mode;
      logic [1:0] code;
      int         r;
      repeat (count) begin
         r = $urandom_range(0, 99);
         mode = (r < 50) ? MODE_TICK : (r < 70) ? MODE_SET :
                (r < 94) ? MODE_CLEAR : MODE_SPARE;
         r = $urandom_range(0, 99);
         code = (r < 55) ? STATUS_PROGRAM : (r < 85) ? STATUS_SHUTDOWN :
                (r < 93) ? STATUS_OTHER : STATUS_SPARE;
         send_request(mode, code, 1'($urandom), 1'($urandom));
      end
   endtask

   // stop offering, wait for all writes and let the front end go quiet
   task automatic settle();
      @(negedge clock);
      req_push <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_step(input logic [7:0] value);
      settle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.ring_step = value;
   endtask

   // run limit
   initial begin
      #(30_000_000);
      $display("tb_led_matrix_status_animator: errors");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // power fade from reset up to full, then a tick with nothing running
      repeat (8) send_request(MODE_TICK, STATUS_PROGRAM, 1'b0, 1'b0);
      // shutdown with no program restarts the fade, now falling
      send_request(MODE_SET, STATUS_SHUTDOWN, 1'b0, 1'b0);
      send_request(MODE_TICK, STATUS_SPARE, 1'b1, 1'b1);
      // shutdown while a program runs is ignored
      send_request(MODE_SET, STATUS_SHUTDOWN, 1'b1, 1'b0);
      // program start clears the matrix, ring ticks follow
      send_request(MODE_SET, STATUS_PROGRAM, 1'b1, 1'b0);
      send_request(MODE_TICK, STATUS_PROGRAM, 1'b1, 1'b0);
      send_request(MODE_TICK, STATUS_PROGRAM, 1'b1, 1'b1);
      // program end during shutdown goes back to the fade
      send_request(MODE_CLEAR, STATUS_PROGRAM, 1'b0, 1'b1);
      send_request(MODE_TICK, STATUS_PROGRAM, 1'b0, 1'b1);
      // plain program end shows the full stop sign
      send_request(MODE_SET, STATUS_PROGRAM, 1'b1, 1'b0);
      send_request(MODE_CLEAR, STATUS_PROGRAM, 1'b0, 1'b0);
      // other status codes, the unused mode and a cleared shutdown
      send_request(MODE_SET, STATUS_OTHER, 1'b0, 1'b0);
      send_request(MODE_SET, STATUS_SPARE, 1'b1, 1'b1);
      send_request(MODE_CLEAR, STATUS_OTHER, 1'b1, 1'b0);
      send_request(MODE_CLEAR, STATUS_SPARE, 1'b1, 1'b1);
      send_request(MODE_SPARE, STATUS_PROGRAM, 1'b0, 1'b0);
      send_request(MODE_CLEAR, STATUS_SHUTDOWN, 1'b0, 1'b0);
      send_request(MODE_TICK, STATUS_PROGRAM, 1'b0, 1'b0);

      // widest step, with a long consumer hold-off at the start
      write_step(8'd255);
      stall_request = 1'b1;
      send_random(75);

      // zero step, back-to-back on both sides
      write_step(8'd0);
      steady = 1'b1;
      send_random(55);
      steady = 1'b0;

      write_step(8'($urandom_range(1, 254)));
      send_random(85);

      write_step(8'($urandom));
      send_random(75);

      settle();
      if (sb.errors == 0)
         $display("tb_led_matrix_status_animator: clean");
      else
         $display("tb_led_matrix_status_animator: errors");
      $finish;
   end

endmodule

// File: files.f
src/lmsa_pkg.sv
src/lmsa_front.sv
src/lmsa_cmdq.sv
src/lmsa_back.sv
src/led_matrix_status_animator.sv
tb/tb_led_matrix_status_animator.sv
